@@ rtl/core/ccs_pkg.sv @@
// ccs_pkg: shared types, constants and the corner-cut helper for the Chaikin subdivider.
// No dependencies.
package ccs_pkg;

  localparam int COORD_W        = 16;
  localparam int LEVELS_W       = 3;
  localparam int MAX_LEVELS_DEF = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pt_x;
    coord_t pt_y;
    logic   pt_last;
  } pt_in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   out_last;
  } pt_out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } ccs_pt_t;

  // floor((3*a + b) / 4)
  function automatic coord_t ccs_cut(coord_t a, coord_t b);
    logic signed [COORD_W+1:0] ax;
    logic signed [COORD_W+1:0] bx;
    logic signed [COORD_W+1:0] s;
    ax = {{2{a[COORD_W-1]}}, a};
    bx = {{2{b[COORD_W-1]}}, b};
    s  = ax + (ax <<< 1) + bx;
    return s[COORD_W+1:2];
  endfunction

endpackage

@@ rtl/core/chaikin_curve_subdivider.sv @@
// chaikin_curve_subdivider: top level, a chain of ccs_cell stages plus the levels register.
// Depends on ccs_pkg and ccs_cell.
//
// Points enter as words on the in_ channel, the final point of a polyline marked by
// pt_last, and leave on the out_ channel. cfg_wdata written with cfg_we sets the
// number of corner-cutting passes (reset 1, values above MAX_LEVELS act as MAX_LEVELS,
// zero passes points through). Each pass is one cell of the chain; each cell puts
// out one word per cycle while not stalled, so the output port runs at one word per
// cycle unless out_ready holds it off. An input word yields up to 2**levels output
// words (16 at four levels), and 2**(levels+1)-1 for the marked final point.
// Every cell, active or not, passes each word through two registers (work register
// and output register). Change cfg_wdata only while no polyline words are in flight.
module chaikin_curve_subdivider
  import ccs_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pt_in_t              in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pt_out_t             out_data,
  input  logic                cfg_we,
  input  logic [LEVELS_W-1:0] cfg_wdata
);

  logic [LEVELS_W-1:0] levels_r, levels_nxt;
  logic [LEVELS_W-1:0] nlev;

  logic    ch_valid [MAX_LEVELS+1];
  logic    ch_ready [MAX_LEVELS+1];
  ccs_pt_t ch_pt    [MAX_LEVELS+1];

  always_comb begin
    levels_nxt = cfg_we ? cfg_wdata : levels_r;
    nlev = (levels_r > LEVELS_W'(MAX_LEVELS)) ? LEVELS_W'(MAX_LEVELS) : levels_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LEVELS_W'(1);
    end else begin
      levels_r <= levels_nxt;
    end
  end

  assign ch_valid[0]  = in_valid;
  assign in_ready     = ch_ready[0];
  assign ch_pt[0].x    = in_data.pt_x;
  assign ch_pt[0].y    = in_data.pt_y;
  assign ch_pt[0].last = in_data.pt_last;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    ccs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bypass    (LEVELS_W'(i) >= nlev),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_pt     (ch_pt[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_pt    (ch_pt[i+1])
    );
  end

  assign out_valid             = ch_valid[MAX_LEVELS];
  assign ch_ready[MAX_LEVELS]  = out_ready;
  assign out_data.out_x        = ch_pt[MAX_LEVELS].x;
  assign out_data.out_y        = ch_pt[MAX_LEVELS].y;
  assign out_data.out_last     = ch_pt[MAX_LEVELS].last;

endmodule

@@ rtl/core/ccs_cell.sv @@
// ccs_cell: one corner-cutting stage with its predecessor store and output register.
// Depends on ccs_pkg.
module ccs_cell
  import ccs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    bypass,
  input  logic    in_valid,
  output logic    in_ready,
  input  ccs_pt_t in_pt,
  output logic    out_valid,
  input  logic    out_ready,
  output ccs_pt_t out_pt
);

  typedef enum logic [1:0] {STEP_Q, STEP_R, STEP_P} step_t;

  // control
  logic    work_valid_r, work_valid_nxt;
  logic    pair_r, pair_nxt;
  step_t   step_r, step_nxt;
  logic    have_prev_r, have_prev_nxt;
  logic    ov_r, ov_nxt;
  // payload
  ccs_pt_t wp_r, wp_nxt;
  coord_t  wa_x_r, wa_x_nxt;
  coord_t  wa_y_r, wa_y_nxt;
  coord_t  prev_x_r, prev_x_nxt;
  coord_t  prev_y_r, prev_y_nxt;
  ccs_pt_t od_r, od_nxt;

  logic    can_emit;
  logic    is_final;
  logic    accept;
  ccs_pt_t word;

  always_comb begin
    can_emit = work_valid_r && (!ov_r || out_ready);
    is_final = !pair_r || (step_r == STEP_P) || ((step_r == STEP_R) && !wp_r.last);
    in_ready = !work_valid_r || (can_emit && is_final);
    accept   = in_valid && in_ready;

    word = wp_r;
    if (pair_r) begin
      case (step_r)
        STEP_Q: begin
          word.x    = ccs_cut(wa_x_r, wp_r.x);
          word.y    = ccs_cut(wa_y_r, wp_r.y);
          word.last = 1'b0;
        end
        STEP_R: begin
          word.x    = ccs_cut(wp_r.x, wa_x_r);
          word.y    = ccs_cut(wp_r.y, wa_y_r);
          word.last = 1'b0;
        end
        STEP_P: word = wp_r;
        default: word = wp_r;
      endcase
    end
  end

  always_comb begin
    work_valid_nxt = work_valid_r;
    pair_nxt       = pair_r;
    step_nxt       = step_r;
    have_prev_nxt  = have_prev_r;
    ov_nxt         = ov_r;
    wp_nxt         = wp_r;
    wa_x_nxt       = wa_x_r;
    wa_y_nxt       = wa_y_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    od_nxt         = od_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (can_emit) begin
      ov_nxt = 1'b1;
      od_nxt = word;
      if (is_final) begin
        work_valid_nxt = 1'b0;
      end else if (step_r == STEP_Q) begin
        step_nxt = STEP_R;
      end else begin
        step_nxt = STEP_P;
      end
    end
    if (accept) begin
      work_valid_nxt = 1'b1;
      step_nxt       = STEP_Q;
      wp_nxt         = in_pt;
      wa_x_nxt       = prev_x_r;
      wa_y_nxt       = prev_y_r;
      pair_nxt       = !bypass && have_prev_r;
      if (!bypass) begin
        if (!in_pt.last) begin
          have_prev_nxt = 1'b1;
          prev_x_nxt    = in_pt.x;
          prev_y_nxt    = in_pt.y;
        end else begin
          have_prev_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      pair_r       <= 1'b0;
      step_r       <= STEP_Q;
      have_prev_r  <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      pair_r       <= pair_nxt;
      step_r       <= step_nxt;
      have_prev_r  <= have_prev_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wp_r     <= wp_nxt;
    wa_x_r   <= wa_x_nxt;
    wa_y_r   <= wa_y_nxt;
    prev_x_r <= prev_x_nxt;
    prev_y_r <= prev_y_nxt;
    od_r     <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_pt    = od_r;

  // re-emit step only for a marked point that closes a pair
  a_step_p_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r && (step_r == STEP_P) |-> pair_r && wp_r.last)
    else $error("ccs_cell: re-emit step without closing point");

  a_single_step_q: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r && !pair_r |-> step_r == STEP_Q)
    else $error("ccs_cell: single-word item advanced its step");

  a_bypass_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    bypass |=> $stable(have_prev_r))
    else $error("ccs_cell: bypassed stage touched its store");

  a_no_accept_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
    work_valid_r && pair_r && (step_r == STEP_Q) |-> !in_ready)
    else $error("ccs_cell: ready while a pair is pending");

endmodule

@@ bench/tb_chaikin_curve_subdivider.sv @@
// tb_chaikin_curve_subdivider: self-checking bench for the Chaikin corner-cutting subdivider.
// Predicts every output word per accepted point, drives random handshake gaps and level changes.
// Depends on ccs_pkg and chaikin_curve_subdivider.
module tb_chaikin_curve_subdivider;
  import ccs_pkg::*;

  localparam int MAX_LV = MAX_LEVELS_DEF;
  localparam int ITEMS = 260;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  class subdivision_scoreboard;
    coord_t stage_px[MAX_LV];
    coord_t stage_py[MAX_LV];
    bit stage_full[MAX_LV];
    int active_levels;
    pt_out_t pending_points[$];
    int mismatch_count;

    function new();
      foreach (stage_full[i]) begin
        stage_px[i] = '0;
        stage_py[i] = '0;
        stage_full[i] = 1'b0;
      end
      active_levels = 1;
      mismatch_count = 0;
    endfunction

    function void set_levels(logic [LEVELS_W-1:0] v);
      active_levels = (v > MAX_LV) ? MAX_LV : int'(v);
    endfunction

    // floor((3*a + b) / 4)
    static function coord_t corner(coord_t a, coord_t b);
      longint sum;
      sum = 3 * longint'(a) + longint'(b);
      return coord_t'(sum >>> 2);
    endfunction

    function void push_point(pt_in_t w);
      pt_out_t cur[$];
      pt_out_t nxt[$];
      pt_out_t p;
      pt_out_t q;
      p.out_x = w.pt_x;
      p.out_y = w.pt_y;
      p.out_last = w.pt_last;
      cur.push_back(p);
      for (int st = 0; st < active_levels; st++) begin
        nxt.delete();
        foreach (cur[i]) begin
          p = cur[i];
          if (!stage_full[st]) begin
            nxt.push_back(p);
            if (!p.out_last) begin
              stage_px[st] = p.out_x;
              stage_py[st] = p.out_y;
              stage_full[st] = 1'b1;
            end
          end else begin
            q.out_last = 1'b0;
            q.out_x = corner(stage_px[st], p.out_x);
            q.out_y = corner(stage_py[st], p.out_y);
            nxt.push_back(q);
            q.out_x = corner(p.out_x, stage_px[st]);
            q.out_y = corner(p.out_y, stage_py[st]);
            nxt.push_back(q);
            if (p.out_last) begin
              nxt.push_back(p);
              stage_full[st] = 1'b0;
              stage_px[st] = '0;
              stage_py[st] = '0;
            end else begin
              stage_px[st] = p.out_x;
              stage_py[st] = p.out_y;
            end
          end
        end
        cur = nxt;
      end
      foreach (cur[i]) pending_points.push_back(cur[i]);
    endfunction

    function void compare_point(pt_out_t got);
      pt_out_t exp_pt;
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: x=%0d y=%0d last=%0b",
                   got.out_x, got.out_y, got.out_last);
        return;
      end
      exp_pt = pending_points.pop_front();
      if (got.out_x !== exp_pt.out_x || got.out_y !== exp_pt.out_y ||
          got.out_last !== exp_pt.out_last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("word mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   exp_pt.out_x, exp_pt.out_y, exp_pt.out_last,
                   got.out_x, got.out_y, got.out_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pt_out_t out_data;
  logic cfg_we = 1'b0;
  logic [LEVELS_W-1:0] cfg_wdata = '0;

  subdivision_scoreboard sb = new();
  int items_sent = 0;
  int inputs_taken = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit phase_gaps = 1'b1;
  bit hold_done = 1'b0;

  chaikin_curve_subdivider #(.MAX_LEVELS(MAX_LV)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.push_point(in_data);
        inputs_taken++;
      end
      if (out_valid && out_ready) sb.compare_point(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the chain backs up
  initial begin : sink
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && inputs_taken >= 120 && in_valid) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic coord_t any_coord();
    case ($urandom_range(0, 15))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_point(input coord_t x, input coord_t y, input logic last);
    pt_in_t w;
    w.pt_x = x;
    w.pt_y = y;
    w.pt_last = last;
    if (gaps_on && phase_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
  endtask

  // only while the chain is empty
  task automatic write_levels(input logic [LEVELS_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (2 * MAX_LV) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_levels(v);
  endtask

  initial begin : stimulus
    logic [LEVELS_W-1:0] lv;
    int npoly;
    int len;
    bit broken;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset level: single point, then a polyline at the coordinate extremes
    send_point(COORD_MAX, COORD_MIN, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point('0, '0, 1'b1);
    write_levels(3'd0);
    send_point(16'sd1, -16'sd1, 1'b0);
    send_point(-16'sd2, 16'sd3, 1'b1);
    write_levels(3'd4);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(16'sd5, -16'sd7, 1'b1);
    send_point(COORD_MIN, COORD_MAX, 1'b1);
    // level changes in the middle of a polyline; idle stages keep their point
    send_point(16'sd100, -16'sd100, 1'b0);
    send_point(-16'sd3, 16'sd9, 1'b0);
    write_levels(3'd2);
    send_point(16'sd7, 16'sd7, 1'b0);
    write_levels(3'd7);
    send_point(-16'sd1, -16'sd1, 1'b1);
    write_levels(3'd5);
    send_point(COORD_MIN, '0, 1'b1);
    write_levels(3'd6);
    send_point(16'sd12, -16'sd12, 1'b0);
    send_point(-16'sd13, 16'sd13, 1'b1);
    write_levels(3'd3);
    send_point(16'sd4, 16'sd8, 1'b0);
    send_point(-16'sd4, -16'sd8, 1'b1);

    while (items_sent < ITEMS) begin
      lv = $urandom_range(0, 7);
      write_levels(lv);
      phase_gaps = $urandom_range(0, 3) != 0;
      npoly = $urandom_range(1, 3);
      repeat (npoly) begin
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
        broken = $urandom_range(0, 7) == 0;
        for (int k = 0; k < len; k++) begin
          gaps_on = items_sent < ITEMS - 40;
          send_point(any_coord(), any_coord(), k == len - 1 && !broken);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (4 * MAX_LV) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ chaikin_curve_subdivider.f @@
rtl/core/ccs_pkg.sv
rtl/core/ccs_cell.sv
rtl/core/chaikin_curve_subdivider.sv
bench/tb_chaikin_curve_subdivider.sv
